@@ hdl/tknn_pkg.sv @@
// Package for the top-k nearest-neighbour selector: sizes, register indices,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package tknn_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int NIDX_W   = 32;
    localparam int DIST_W   = 16;
    localparam int KEEP_W   = 6;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 2;

    localparam logic [CFG_IX_W-1:0] CFG_MAX_KEPT         = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_THRESHOLD_ENABLE = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_DISTANCE_LIMIT   = 2'd2;

    localparam logic [KEEP_W-1:0] MAX_KEPT_RESET       = 6'd32;
    localparam logic [DIST_W-1:0] DISTANCE_LIMIT_RESET = 16'hFFFF;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;     // candidate transfer accepted
        logic close;      // that candidate is the last of the query
        logic shift_out;  // result transfer accepted
    } dp_cmd_t;

    typedef struct packed {
        logic remain_le_one;
    } dp_status_t;

endpackage

@@ hdl/tknn_ctrl.sv @@
// Controller of the top-k nearest-neighbour selector: collects candidates, then
// streams the kept list. Depends on tknn_pkg.
module tknn_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   last_neighbor,
    input  logic                   out_ready,
    input  tknn_pkg::dp_status_t   status,
    output logic                   in_ready,
    output logic                   out_valid,
    output tknn_pkg::dp_cmd_t      cmd
);
    import tknn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.insert    = 1'b0;
        cmd.close     = 1'b0;
        cmd.shift_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.insert = in_valid;
                cmd.close  = in_valid && last_neighbor;
                if (in_valid && last_neighbor)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.shift_out = out_ready;
                if (out_ready && status.remain_le_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A query never takes candidates while its results are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    // The last candidate is followed by at least one result in the next cycle.
    a_last_starts_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_neighbor) |=> out_valid)
        else $error("no result after the last candidate");

    // Once the final result is taken the block is ready for a new query.
    a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.remain_le_one) |=> (in_ready && !out_valid))
        else $error("block did not return to collecting");

endmodule

@@ hdl/tknn_dpath.sv @@
// Datapath of the top-k nearest-neighbour selector: a row of compare-and-shift
// cells kept in ascending distance order, the fill count and the output count.
// Depends on tknn_pkg.
module tknn_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tknn_pkg::dp_cmd_t            cmd,
    input  logic [tknn_pkg::NIDX_W-1:0]  neighbor_index,
    input  logic [tknn_pkg::DIST_W-1:0]  distance,
    input  logic [tknn_pkg::KEEP_W-1:0]  max_kept,
    input  logic                         threshold_enable,
    input  logic [tknn_pkg::DIST_W-1:0]  distance_limit,
    output logic [tknn_pkg::NIDX_W-1:0]  kept_index,
    output logic [tknn_pkg::DIST_W-1:0]  kept_distance,
    output logic                         last_result,
    output logic                         none_kept,
    output tknn_pkg::dp_status_t         status
);
    import tknn_pkg::*;

    logic [NIDX_W-1:0] idx_reg  [CAPACITY];
    logic [DIST_W-1:0] dist_reg [CAPACITY];
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [CNT_W-1:0]  remain_next;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  fill_trim;
    logic [CNT_W-1:0]  fill_ins;
    logic [CNT_W-1:0]  fill_eff;
    logic [IDX_W-1:0]  lim_m1;
    logic [CAPACITY-1:0] le;
    logic              passed;
    logic              drop;
    logic              do_write;

    // Keep limit: max_kept clipped to the capacity.
    always_comb
    begin
        if (7'(max_kept) > 7'(CAPACITY))
        begin
            lim = CNT_W'(CAPACITY);
        end
        else
        begin
            lim = CNT_W'(max_kept);
        end
        fill_trim = (fill_count_reg > lim) ? lim : fill_count_reg;
        lim_m1    = IDX_W'(lim - CNT_W'(1));
    end

    // Entries at or nearer than the candidate form a prefix of the sorted row.
    always_comb
    begin
        for (int j = 0; j < CAPACITY; j++)
        begin
            le[j] = (CNT_W'(j) < fill_trim) && (dist_reg[j] <= distance);
        end
    end

    always_comb
    begin
        passed = !(threshold_enable && (distance > distance_limit));
        drop   = (lim == '0) || le[lim_m1];
        if (lim == '0)
        begin
            fill_ins = '0;
        end
        else if (drop)
        begin
            fill_ins = fill_trim;
        end
        else if (fill_trim < lim)
        begin
            fill_ins = fill_trim + CNT_W'(1);
        end
        else
        begin
            fill_ins = fill_trim;
        end
        fill_eff = (cmd.insert && passed) ? fill_ins : fill_count_reg;
        do_write = cmd.insert && passed && !drop;
    end

    always_comb
    begin
        fill_count_next = fill_count_reg;
        remain_next     = remain_reg;
        if (cmd.close)
        begin
            fill_count_next = '0;
            remain_next     = (fill_eff > lim) ? lim : fill_eff;
        end
        else if (cmd.insert)
        begin
            fill_count_next = fill_eff;
        end
        else if (cmd.shift_out && (remain_reg != '0))
        begin
            remain_next = remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            remain_reg     <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            remain_reg     <= remain_next;
        end
    end

    // Each cell keeps its entry, takes the candidate, or takes its nearer
    // neighbour's entry; during output the row moves one place towards cell 0.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic              take_new;
        logic [NIDX_W-1:0] idx_prev;
        logic [DIST_W-1:0] dist_prev;
        logic [NIDX_W-1:0] idx_succ;
        logic [DIST_W-1:0] dist_succ;

        if (g == 0)
        begin : g_head
            assign take_new  = !le[g];
            assign idx_prev  = idx_reg[g];
            assign dist_prev = dist_reg[g];
        end
        else
        begin : g_body
            assign take_new  = !le[g] && le[g-1];
            assign idx_prev  = idx_reg[g-1];
            assign dist_prev = dist_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign idx_succ  = idx_reg[g];
            assign dist_succ = dist_reg[g];
        end
        else
        begin : g_inner
            assign idx_succ  = idx_reg[g+1];
            assign dist_succ = dist_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.shift_out)
            begin
                idx_reg[g]  <= idx_succ;
                dist_reg[g] <= dist_succ;
            end
            else if (do_write && !le[g])
            begin
                idx_reg[g]  <= take_new ? neighbor_index : idx_prev;
                dist_reg[g] <= take_new ? distance : dist_prev;
            end
        end
    end

    assign none_kept            = (remain_reg == '0);
    assign last_result          = (remain_reg <= CNT_W'(1));
    assign kept_index           = none_kept ? '0 : idx_reg[0];
    assign kept_distance        = none_kept ? '0 : dist_reg[0];
    assign status.remain_le_one = last_result;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg <= CNT_W'(CAPACITY)) && (remain_reg <= CNT_W'(CAPACITY)))
        else $error("count beyond capacity");

    // Closing a query empties the list for the next one.
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> (fill_count_reg == '0))
        else $error("list not cleared at end of query");

    // A query is only closed by the transfer of its last candidate.
    a_close_with_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> cmd.insert)
        else $error("query closed without a candidate transfer");

endmodule

@@ hdl/top_k_nearest_neighbor_select_core.sv @@
// Top level of the top-k nearest-neighbour selector: configuration registers,
// controller and sorting datapath. Depends on tknn_pkg, tknn_ctrl and tknn_dpath.
// Candidates are taken one per cycle while collecting; each is sorted in on the same edge.
// After the last candidate the first result is offered in the next cycle, then one result
// per cycle while out_ready is high: min(fill, max_kept) results, or one empty-list result.
// A new query is taken in the cycle after the final result transfer.
// Reset (rst_n low, asynchronous) empties the list and restores the register defaults.
module top_k_nearest_neighbor_select_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tknn_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [tknn_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tknn_pkg::NIDX_W-1:0]    neighbor_index,
    input  logic [tknn_pkg::DIST_W-1:0]    distance,
    input  logic                           last_neighbor,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tknn_pkg::NIDX_W-1:0]    kept_index,
    output logic [tknn_pkg::DIST_W-1:0]    kept_distance,
    output logic                           last_result,
    output logic                           none_kept
);
    import tknn_pkg::*;

    logic [KEEP_W-1:0] max_kept_reg;
    logic              threshold_enable_reg;
    logic [DIST_W-1:0] distance_limit_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_kept_reg         <= MAX_KEPT_RESET;
            threshold_enable_reg <= 1'b0;
            distance_limit_reg   <= DISTANCE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAX_KEPT:         max_kept_reg         <= cfg_wdata[KEEP_W-1:0];
                CFG_THRESHOLD_ENABLE: threshold_enable_reg <= cfg_wdata[0];
                CFG_DISTANCE_LIMIT:   distance_limit_reg   <= cfg_wdata[DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tknn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last_neighbor (last_neighbor),
        .out_ready     (out_ready),
        .status        (status),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .cmd           (cmd)
    );

    tknn_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .neighbor_index   (neighbor_index),
        .distance         (distance),
        .max_kept         (max_kept_reg),
        .threshold_enable (threshold_enable_reg),
        .distance_limit   (distance_limit_reg),
        .kept_index       (kept_index),
        .kept_distance    (kept_distance),
        .last_result      (last_result),
        .none_kept        (none_kept),
        .status           (status)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the top-k nearest-neighbour selector core.
// Needs tknn_pkg and top_k_nearest_neighbor_select_core; drives candidates and checks
// every kept-neighbour transfer against a predictor kept in this file.
module tb;
    import tknn_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 27;
    localparam int PHASE_COUNT  = 12;

    typedef struct packed {
        logic [NIDX_W-1:0] index;
        logic [DIST_W-1:0] nn_dist;
        logic              last;
    } candidate_t;

    typedef struct packed {
        logic [NIDX_W-1:0] index;
        logic [DIST_W-1:0] nn_dist;
        logic              last;
        logic              none;
    } neighbor_result_t;

    typedef enum int {
        DIST_SPREAD,
        DIST_TIED,
        DIST_AT_LIMIT,
        DIST_EXTREME
    } dist_style_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]    cfg_wdata      = '0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [NIDX_W-1:0]   neighbor_index = '0;
    logic [DIST_W-1:0]   distance       = '0;
    logic                last_neighbor  = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [NIDX_W-1:0]   kept_index;
    logic [DIST_W-1:0]   kept_distance;
    logic                last_result;
    logic                none_kept;

    // Register copies used by the predictor.
    logic [KEEP_W-1:0]   cfg_max_kept       = MAX_KEPT_RESET;
    logic                cfg_threshold_on   = 1'b0;
    logic [DIST_W-1:0]   cfg_distance_limit = DISTANCE_LIMIT_RESET;

    // Predicted contents of the sorted list.
    logic [NIDX_W-1:0]   list_index [CAPACITY];
    logic [DIST_W-1:0]   list_dist  [CAPACITY];
    int                  list_fill = 0;

    candidate_t          candidate_queue[$];
    neighbor_result_t    expected_neighbors[$];

    int send_idle_pct  = 18;
    int recv_idle_pct  = 86;
    bit pressure_on    = 1'b0;
    int error_count    = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int queries_closed = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    top_k_nearest_neighbor_select_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .neighbor_index (neighbor_index),
        .distance       (distance),
        .last_neighbor  (last_neighbor),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kept_index     (kept_index),
        .kept_distance  (kept_distance),
        .last_result    (last_result),
        .none_kept      (none_kept)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int keep_limit();
        return (int'(cfg_max_kept) > CAPACITY) ? CAPACITY : int'(cfg_max_kept);
    endfunction

    // Stable insertion: a new candidate goes after every entry of equal distance.
    task automatic sort_in_candidate(input logic [NIDX_W-1:0] idx,
                                     input logic [DIST_W-1:0] nn_dist);
        int lim;
        int fill;
        int pos;
        lim  = keep_limit();
        fill = (list_fill > lim) ? lim : list_fill;
        if (lim == 0) begin
            list_fill = 0;
        end
        else begin
            pos = 0;
            while (pos < fill && list_dist[pos] <= nn_dist)
                pos++;
            if (pos >= lim) begin
                list_fill = fill;
            end
            else begin
                if (fill < lim)
                    fill++;
                for (int j = fill - 1; j > pos; j--) begin
                    list_index[j] = list_index[j-1];
                    list_dist[j]  = list_dist[j-1];
                end
                list_index[pos] = idx;
                list_dist[pos]  = nn_dist;
                list_fill       = fill;
            end
        end
    endtask

    task automatic predict_candidate(input candidate_t c);
        int n;
        neighbor_result_t r;
        if (!(cfg_threshold_on && c.nn_dist > cfg_distance_limit))
            sort_in_candidate(c.index, c.nn_dist);
        if (c.last) begin
            n = (list_fill > keep_limit()) ? keep_limit() : list_fill;
            list_fill = 0;
            queries_closed++;
            if (n == 0) begin
                r = '{index: '0, nn_dist: '0, last: 1'b1, none: 1'b1};
                expected_neighbors.insert(expected_neighbors.size(), r);
            end
            else begin
                for (int k = 0; k < n; k++) begin
                    r = '{index: list_index[k], nn_dist: list_dist[k],
                          last: (k == n - 1), none: 1'b0};
                    expected_neighbors.insert(expected_neighbors.size(), r);
                end
            end
        end
    endtask

    task automatic check_result();
        neighbor_result_t want;
        if (expected_neighbors.size() == 0) begin
            report_mismatch($sformatf("result %h/%h with no expectation waiting",
                                      kept_index, kept_distance));
            return;
        end
        want = expected_neighbors.pop_front();
        results_seen++;
        if (kept_index !== want.index)
            report_mismatch($sformatf("kept_index %h, expected %h", kept_index, want.index));
        if (kept_distance !== want.nn_dist)
            report_mismatch($sformatf("kept_distance %h, expected %h", kept_distance,
                                      want.nn_dist));
        if (last_result !== want.last)
            report_mismatch($sformatf("last_result %b, expected %b", last_result, want.last));
        if (none_kept !== want.none)
            report_mismatch($sformatf("none_kept %b, expected %b", none_kept, want.none));
    endtask

    // Candidate driver: the payload is held until the transfer takes place.
    always @(posedge clk or negedge rst_n) begin
        candidate_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_candidate('{index: neighbor_index, nn_dist: distance,
                                    last: last_neighbor});
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (candidate_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = candidate_queue.pop_front();
                    in_valid       <= 1'b1;
                    neighbor_index <= c.index;
                    distance       <= c.nn_dist;
                    last_neighbor  <= c.last;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver; a rise of pressure_on starts a long hold-off.
    always @(posedge clk or negedge rst_n) begin
        static int hold_left     = 0;
        static bit pressure_seen = 1'b0;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready)
                check_result();
            if (pressure_on && !pressure_seen)
                hold_left = HOLD_CYCLES;
            pressure_seen = pressure_on;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
                $display("top_k_nearest_neighbor_select_core verification failed");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ix;
        cfg_wdata <= value;
        case (ix)
            CFG_MAX_KEPT:         cfg_max_kept       = value[KEEP_W-1:0];
            CFG_THRESHOLD_ENABLE: cfg_threshold_on   = value[0];
            CFG_DISTANCE_LIMIT:   cfg_distance_limit = value[DIST_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_candidate(input logic [NIDX_W-1:0] idx,
                                   input logic [DIST_W-1:0] nn_dist,
                                   input logic last);
        candidate_t c;
        c = '{index: idx, nn_dist: nn_dist, last: last};
        candidate_queue.insert(candidate_queue.size(), c);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance(input dist_style_t style);
        int d;
        case (style)
            DIST_TIED:     d = $urandom_range(3) * 'h1000 + 'h0800;
            DIST_AT_LIMIT: d = int'(cfg_distance_limit) + $urandom_range(4) - 2;
            DIST_EXTREME:  d = $urandom_range(1) ? 'hFFFF : 0;
            default:       d = $urandom_range(65535);
        endcase
        if (d < 0)
            d = 0;
        if (d > 65535)
            d = 65535;
        return d[DIST_W-1:0];
    endfunction

    task automatic queue_random_query(input int len, input dist_style_t style, input bit close);
        dist_style_t s;
        for (int i = 0; i < len; i++) begin
            // A share of noise candidates keeps every distance bit moving.
            s = ($urandom_range(4) == 0) ? DIST_SPREAD : style;
            queue_candidate($urandom, pick_distance(s), close && (i == len - 1));
        end
    endtask

    // The block is idle once every expected result has arrived; the extra cycles cover
    // a candidate that was still being sorted in.
    task automatic wait_until_idle();
        @(negedge clk);
        while (candidate_queue.size() != 0 || in_valid || expected_neighbors.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial begin
        int          phase_items;
        int          len;
        bit          close;
        dist_style_t style;
        logic [CFG_W-1:0] value;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first under the reset register values.
        queue_candidate(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        queue_candidate(32'h0000_0000, 16'h0000, 1'b0);
        queue_candidate(32'd5, 16'h0000, 1'b0);
        queue_candidate(32'd7, 16'd100, 1'b0);
        queue_candidate(32'd8, 16'd50, 1'b1);
        wait_until_idle();
        settings_used++;

        // A count of zero keeps nothing and closes as an empty list.
        write_register(CFG_MAX_KEPT, 16'd0);
        queue_candidate(32'd1, 16'd10, 1'b0);
        queue_candidate(32'd2, 16'd20, 1'b1);
        wait_until_idle();
        settings_used++;

        // Count above capacity, threshold on: one survivor, then an all-dropped query.
        write_register(CFG_MAX_KEPT, 16'd63);
        write_register(CFG_THRESHOLD_ENABLE, 16'd1);
        write_register(CFG_DISTANCE_LIMIT, 16'h4000);
        queue_candidate(32'd3, 16'h4000, 1'b0);
        queue_candidate(32'd4, 16'h4001, 1'b0);
        queue_candidate(32'd5, 16'hFFFF, 1'b1);
        queue_candidate(32'd6, 16'h4001, 1'b1);
        wait_until_idle();
        settings_used++;

        // Full list: candidates not nearer than the farthest entry are dropped.
        write_register(CFG_MAX_KEPT, 16'd2);
        write_register(CFG_THRESHOLD_ENABLE, 16'd0);
        queue_candidate(32'd10, 16'd10, 1'b0);
        queue_candidate(32'd11, 16'd20, 1'b0);
        queue_candidate(32'd12, 16'd20, 1'b0);
        queue_candidate(32'd13, 16'd30, 1'b0);
        queue_candidate(32'd14, 16'd5, 1'b1);
        wait_until_idle();
        settings_used++;

        // Registers changed in the middle of a query; the list is cut at output.
        write_register(CFG_MAX_KEPT, 16'd3);
        queue_candidate(32'd20, 16'h9000, 1'b0);
        queue_candidate(32'd21, 16'h8000, 1'b0);
        queue_candidate(32'd22, 16'h7000, 1'b0);
        queue_candidate(32'd23, 16'h6000, 1'b0);
        queue_candidate(32'd24, 16'h0200, 1'b0);
        wait_until_idle();
        write_register(CFG_MAX_KEPT, 16'd1);
        write_register(CFG_THRESHOLD_ENABLE, 16'd1);
        write_register(CFG_DISTANCE_LIMIT, 16'h0100);
        queue_candidate(32'd25, 16'h0300, 1'b1);
        wait_until_idle();
        settings_used++;

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            @(negedge clk);
            if (phase == PHASE_COUNT / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 18;
            end
            else if (phase == 2 * PHASE_COUNT / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pressure_on = (phase == 2 * PHASE_COUNT / 3 + 1);

            case ($urandom_range(5))
                0:       value = 16'd0;
                1:       value = 16'd1;
                2:       value = 16'd32;
                3:       value = CFG_W'($urandom_range(63, 33));
                default: value = CFG_W'($urandom_range(8, 2));
            endcase
            write_register(CFG_MAX_KEPT, value);
            write_register(CFG_THRESHOLD_ENABLE, CFG_W'($urandom_range(1)));
            case ($urandom_range(4))
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                2:       value = CFG_W'($urandom_range(16'h5A82));
                default: value = CFG_W'($urandom_range(65535));
            endcase
            write_register(CFG_DISTANCE_LIMIT, value);
            settings_used++;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                len   = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(40, 7);
                style = dist_style_t'($urandom_range(3));
                // The last query of a phase may be left open across the next register writes.
                close = (phase_items + len < PHASE_ITEMS) || (phase == PHASE_COUNT - 1) ||
                        ($urandom_range(3) != 0);
                queue_random_query(len, style, close);
                phase_items += len;
            end
            wait_until_idle();
        end

        repeat (10) @(negedge clk);
        $display("Covered %0d candidates in %0d queries, %0d results checked, %0d settings.",
                 items_accepted, queries_closed, results_seen, settings_used);
        $display("Idle mixes on both sides and a %0d-cycle receiver hold-off were exercised.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("top_k_nearest_neighbor_select_core verification clean");
        else
            $display("top_k_nearest_neighbor_select_core verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tknn_pkg.sv
hdl/tknn_ctrl.sv
hdl/tknn_dpath.sv
hdl/top_k_nearest_neighbor_select_core.sv
dv/tb.sv
